@@ hdl/trilateration_2d_three_anchor_top_defines.svh @@
// ----------------------------------------------------------------------------
// trilateration assertion macros
// shared assertion forms for the trilateration solver
// ----------------------------------------------------------------------------
`ifndef TRILATERATION_2D_THREE_ANCHOR_TOP_DEFINES_SVH
`define TRILATERATION_2D_THREE_ANCHOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TRI_ASSERT_IMP(label, ck, rn, a, c) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (c)) \
    else $error("trilateration check failed");
`define TRI_ASSERT_NXT(label, ck, rn, a, c) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (c)) \
    else $error("trilateration check failed");
`else
`define TRI_ASSERT_IMP(label, ck, rn, a, c)
`define TRI_ASSERT_NXT(label, ck, rn, a, c)
`endif

`endif

@@ hdl/trilat_pkg.sv @@
// ----------------------------------------------------------------------------
// trilat_pkg
// shared constants for the trilateration solver
// ----------------------------------------------------------------------------
`default_nettype none
package trilat_pkg;
  localparam int OUT_W    = 32;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] FIX_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] FIX_DEGEN = 2'd1;
  localparam logic [STATUS_W-1:0] FIX_SAT   = 2'd2;

  typedef struct packed {
    logic sat;
  } trilat_div_flags_t;
endpackage
`default_nettype wire

@@ hdl/trilat_div.sv @@
// ----------------------------------------------------------------------------
// trilat_div
// pipelined signed divider, one quotient bit per stage, 32-bit saturated
// ----------------------------------------------------------------------------
`default_nettype none
module trilat_div #(
  parameter int NW  = 77,
  parameter int DNW = 52
) (
  input  wire logic                            clk,
  input  wire logic                            adv,
  input  wire logic signed [NW-1:0]            num,
  input  wire logic signed [DNW-1:0]           den,
  output logic        [trilat_pkg::OUT_W-1:0]  quot,
  output trilat_pkg::trilat_div_flags_t        flags
);
  import trilat_pkg::*;

  localparam int XW = (NW > DNW + OUT_W) ? NW : DNW + OUT_W;

  logic [NW-1:0]  num_a_r;
  logic [DNW-1:0] den_a_r;
  logic           neg_a_r;

  logic [XW-1:0]    rem_r [0:OUT_W];
  logic [OUT_W-1:0] q_r   [0:OUT_W];
  logic [DNW-1:0]   den_r [0:OUT_W];
  logic             neg_r [0:OUT_W];
  logic             ovf_r [0:OUT_W];

  logic [OUT_W-1:0] quot_r;
  logic             sat_r;

  // magnitudes and sign
  always_ff @(posedge clk) begin
    if (adv) begin
      neg_a_r <= num[NW-1] ^ den[DNW-1];
      num_a_r <= num[NW-1] ? (~$unsigned(num) + 1'b1) : $unsigned(num);
      den_a_r <= den[DNW-1] ? (~$unsigned(den) + 1'b1) : $unsigned(den);
    end
  end

  // quotient at or above 2^32
  always_ff @(posedge clk) begin
    if (adv) begin
      ovf_r[0] <= XW'(num_a_r) >= (XW'(den_a_r) << OUT_W);
      rem_r[0] <= XW'(num_a_r);
      den_r[0] <= den_a_r;
      neg_r[0] <= neg_a_r;
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < OUT_W; k++) begin : g_step
    logic [XW-1:0] dsh;
    logic          ge;
    assign dsh = XW'(den_r[k]) << (OUT_W - 1 - k);
    assign ge  = rem_r[k] >= dsh;
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= ge ? (rem_r[k] - dsh) : rem_r[k];
        q_r[k+1]   <= q_r[k] | (ge ? (OUT_W'(1) << (OUT_W - 1 - k)) : '0);
        den_r[k+1] <= den_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  // sign and saturation
  always_ff @(posedge clk) begin
    if (adv) begin
      if (!neg_r[OUT_W]) begin
        if (ovf_r[OUT_W] || q_r[OUT_W][OUT_W-1]) begin
          quot_r <= {1'b0, {(OUT_W-1){1'b1}}};
          sat_r  <= 1'b1;
        end else begin
          quot_r <= q_r[OUT_W];
          sat_r  <= 1'b0;
        end
      end else begin
        if (ovf_r[OUT_W] || (q_r[OUT_W] > {1'b1, {(OUT_W-1){1'b0}}})) begin
          quot_r <= {1'b1, {(OUT_W-1){1'b0}}};
          sat_r  <= 1'b1;
        end else begin
          quot_r <= ~q_r[OUT_W] + 1'b1;
          sat_r  <= 1'b0;
        end
      end
    end
  end

  assign quot      = quot_r;
  assign flags.sat = sat_r;
endmodule
`default_nettype wire

@@ hdl/trilateration_2d_three_anchor_top.sv @@
// ----------------------------------------------------------------------------
// trilateration_2d_three_anchor_top
// three-anchor 2d position fix by cramer's rule with pipelined division
// ----------------------------------------------------------------------------
// channel  dir  tdata                                       tuser
// in_      in   3 x {x, y, range} anchors, first lowest     -
// out_     out  {target_y, target_x}, target_x lowest       fix_status
//
// one request per cycle while the output is not stalled; 6 arithmetic stages,
// 35 divider stages (32 of them one quotient bit each), one output register.
// the divider's 32 quotient-bit stages set the depth.
// reset clears the valid bits only; data registers are not reset.
// a stall at the output freezes every stage; in_tready follows it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "trilateration_2d_three_anchor_top_defines.svh"
module trilateration_2d_three_anchor_top #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // first_x, first_y, first_range, second_x, second_y, second_range,
  // third_x, third_y, third_range, zero pad
  input  wire logic [((3*(3*COORD_WIDTH-1)+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // target_x, target_y
  output logic [2*trilat_pkg::OUT_W-1:0]  out_tdata,
  // fix_status
  output logic [trilat_pkg::STATUS_W-1:0] out_tuser
);
  import trilat_pkg::*;

  localparam int CW      = COORD_WIDTH;
  localparam int RW      = CW - 1;
  localparam int FS      = 3 * CW - 1;
  localparam int DW      = CW + 1;
  localparam int PW      = 2 * DW;
  localparam int RSW     = 2 * RW;
  localparam int CWD     = 2 * DW + 1;
  localparam int DTW     = 2 * DW + 1;
  localparam int DNW     = DTW + 1;
  localparam int CL      = (CWD + 1) / 2;
  localparam int CH      = CWD - CL;
  localparam int LPW     = CL + 1 + DW;
  localparam int HPW     = CH + DW;
  localparam int MW      = CWD + DW;
  localparam int NW      = MW + 1;
  localparam int DIV_LAT = OUT_W + 3;
  localparam int NS      = 6 + DIV_LAT;
  localparam int DG_N    = DIV_LAT + 3;

  logic adv;
  assign adv       = out_tready | ~out_tvalid;
  assign in_tready = adv;

  logic signed [CW-1:0] xi, yi, xj, yj, xk, yk;
  logic        [RW-1:0] ri, rj, rk;
  assign xi = in_tdata[0*FS +: CW];
  assign yi = in_tdata[0*FS + CW +: CW];
  assign ri = in_tdata[0*FS + 2*CW +: RW];
  assign xj = in_tdata[1*FS +: CW];
  assign yj = in_tdata[1*FS + CW +: CW];
  assign rj = in_tdata[1*FS + 2*CW +: RW];
  assign xk = in_tdata[2*FS +: CW];
  assign yk = in_tdata[2*FS + CW +: CW];
  assign rk = in_tdata[2*FS + 2*CW +: RW];

  logic [NS-1:0]   vld_r;
  logic [DG_N-1:0] dg_r;

  // stage 1: differences and sums
  logic signed [DW-1:0] a1_r, b1_r, a2_r, b2_r, sx1_r, sy1_r, sx2_r, sy2_r;
  logic        [RW-1:0] ri_r, rj_r, rk_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r  <= DW'(xj) - DW'(xi);
      b1_r  <= DW'(yj) - DW'(yi);
      a2_r  <= DW'(xk) - DW'(xi);
      b2_r  <= DW'(yk) - DW'(yi);
      sx1_r <= DW'(xj) + DW'(xi);
      sy1_r <= DW'(yj) + DW'(yi);
      sx2_r <= DW'(xk) + DW'(xi);
      sy2_r <= DW'(yk) + DW'(yi);
      ri_r  <= ri;
      rj_r  <= rj;
      rk_r  <= rk;
    end
  end

  // stage 2: products
  logic        [RSW-1:0] rii_r, rjj_r, rkk_r;
  logic signed [PW-1:0]  pa1_r, pb1_r, pa2_r, pb2_r, d1_r, d2_r;
  logic signed [DW-1:0]  a1_2r, b1_2r, a2_2r, b2_2r;
  always_ff @(posedge clk) begin
    if (adv) begin
      rii_r <= ri_r * ri_r;
      rjj_r <= rj_r * rj_r;
      rkk_r <= rk_r * rk_r;
      pa1_r <= a1_r * sx1_r;
      pb1_r <= b1_r * sy1_r;
      pa2_r <= a2_r * sx2_r;
      pb2_r <= b2_r * sy2_r;
      d1_r  <= a1_r * b2_r;
      d2_r  <= a2_r * b1_r;
      a1_2r <= a1_r;
      b1_2r <= b1_r;
      a2_2r <= a2_r;
      b2_2r <= b2_r;
    end
  end

  // stage 3: right-hand sides and determinant
  logic signed [CWD-1:0] c1_r, c2_r;
  logic signed [DTW-1:0] det_r;
  logic signed [DW-1:0]  a1_3r, b1_3r, a2_3r, b2_3r;
  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r  <= $signed({1'b0, rii_r}) - $signed({1'b0, rjj_r}) + pa1_r + pb1_r;
      c2_r  <= $signed({1'b0, rii_r}) - $signed({1'b0, rkk_r}) + pa2_r + pb2_r;
      det_r <= DTW'(d1_r) - DTW'(d2_r);
      a1_3r <= a1_2r;
      b1_3r <= b1_2r;
      a2_3r <= a2_2r;
      b2_3r <= b2_2r;
    end
  end

  // stage 4: split partial products
  logic signed [LPW-1:0] l_c1b2_r, l_c2b1_r, l_a1c2_r, l_a2c1_r;
  logic signed [HPW-1:0] h_c1b2_r, h_c2b1_r, h_a1c2_r, h_a2c1_r;
  logic signed [DNW-1:0] den4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      l_c1b2_r <= $signed({1'b0, c1_r[CL-1:0]}) * b2_3r;
      h_c1b2_r <= $signed(c1_r[CWD-1:CL]) * b2_3r;
      l_c2b1_r <= $signed({1'b0, c2_r[CL-1:0]}) * b1_3r;
      h_c2b1_r <= $signed(c2_r[CWD-1:CL]) * b1_3r;
      l_a1c2_r <= $signed({1'b0, c2_r[CL-1:0]}) * a1_3r;
      h_a1c2_r <= $signed(c2_r[CWD-1:CL]) * a1_3r;
      l_a2c1_r <= $signed({1'b0, c1_r[CL-1:0]}) * a2_3r;
      h_a2c1_r <= $signed(c1_r[CWD-1:CL]) * a2_3r;
      den4_r   <= {det_r, 1'b0};
    end
  end

  // stage 5: recombine partial products
  logic signed [MW-1:0]  m_c1b2_r, m_c2b1_r, m_a1c2_r, m_a2c1_r;
  logic signed [DNW-1:0] den5_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      m_c1b2_r <= (MW'(h_c1b2_r) << CL) + MW'(l_c1b2_r);
      m_c2b1_r <= (MW'(h_c2b1_r) << CL) + MW'(l_c2b1_r);
      m_a1c2_r <= (MW'(h_a1c2_r) << CL) + MW'(l_a1c2_r);
      m_a2c1_r <= (MW'(h_a2c1_r) << CL) + MW'(l_a2c1_r);
      den5_r   <= den4_r;
    end
  end

  // stage 6: numerators
  logic signed [NW-1:0]  nx_r, ny_r;
  logic signed [DNW-1:0] den6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r   <= NW'(m_c1b2_r) - NW'(m_c2b1_r);
      ny_r   <= NW'(m_a1c2_r) - NW'(m_a2c1_r);
      den6_r <= den5_r;
    end
  end

  // valid and degenerate flags travel beside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dg_r <= {dg_r[DG_N-2:0], (det_r == '0)};
    end
  end

  logic [OUT_W-1:0]  qx, qy;
  trilat_div_flags_t fx, fy;

  trilat_div #(.NW(NW), .DNW(DNW)) u_div_x (
    .clk   (clk),
    .adv   (adv),
    .num   (nx_r),
    .den   (den6_r),
    .quot  (qx),
    .flags (fx)
  );

  trilat_div #(.NW(NW), .DNW(DNW)) u_div_y (
    .clk   (clk),
    .adv   (adv),
    .num   (ny_r),
    .den   (den6_r),
    .quot  (qy),
    .flags (fy)
  );

  // output register
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_x_r, out_y_r;
  logic [STATUS_W-1:0] out_st_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dg_r[DG_N-1]) begin
        out_x_r  <= '0;
        out_y_r  <= '0;
        out_st_r <= FIX_DEGEN;
      end else begin
        out_x_r  <= qx;
        out_y_r  <= qy;
        out_st_r <= (fx.sat | fy.sat) ? FIX_SAT : FIX_OK;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_st_r;

  `TRI_ASSERT_IMP(a_degen_zero, clk, rst_n, out_tvalid && (out_tuser == FIX_DEGEN), out_tdata == '0)
  `TRI_ASSERT_IMP(a_status_legal, clk, rst_n, out_tvalid, (out_tuser == FIX_OK) || (out_tuser == FIX_DEGEN) || (out_tuser == FIX_SAT))
  `TRI_ASSERT_IMP(a_sat_extreme, clk, rst_n, out_tvalid && (out_tuser == FIX_SAT), (out_x_r == {1'b0, {(OUT_W-1){1'b1}}}) || (out_x_r == {1'b1, {(OUT_W-1){1'b0}}}) || (out_y_r == {1'b0, {(OUT_W-1){1'b1}}}) || (out_y_r == {1'b1, {(OUT_W-1){1'b0}}}))
  `TRI_ASSERT_NXT(a_pipe_exit, clk, rst_n, vld_r[NS-1] && adv, out_tvalid)
endmodule
`default_nettype wire
